@@ design/mcrc_pkg.sv @@
// Shared types, constants and the CRC-32 byte update for the mailbox service engine.
package mcrc_pkg;

  localparam int unsigned StoreDepth = 256;
  localparam int unsigned StoreAddrW = 8;
  localparam int unsigned BitsPerByte = 8;

  localparam logic [31:0] CrcPoly = 32'hedb8_8320;
  localparam logic [31:0] CrcOnes = 32'hffff_ffff;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusBadLength = 2'd1;
  localparam logic [1:0] StatusUnsupported = 2'd2;

  localparam logic [7:0] CfgPingOpcode = 8'd0;
  localparam logic [7:0] CfgCrcOpcode = 8'd1;

  localparam logic [7:0] PingOpcodeReset = 8'd0;
  localparam logic [7:0] CrcOpcodeReset = 8'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // write one payload byte
    logic poll;       // service tick answered at once
    logic crc_begin;  // service tick that starts a checksum walk
    logic run;        // one step of the checksum walk
    logic finish;     // store the checksum and raise the result strobe
  } mcrc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic poll_mode;    // the offered item is a service tick
    logic crc_request;  // the offered tick runs a new checksum request
    logic crc_done;     // every payload byte of the walk has been folded in
  } mcrc_stat_t;

  // Reflected CRC-32 update over one byte, one bit per step.
  function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] data);
    logic [31:0] c;
    c = acc ^ {24'd0, data};
    for (int b = 0; b < BitsPerByte; b++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

endpackage

@@ design/mcrc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module mcrc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/mcrc_ctrl.sv @@
// Controller state machine: accepts items and sequences the checksum walk.
module mcrc_ctrl import mcrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  mcrc_stat_t stat_i,
  output mcrc_cmd_t  cmd_o,
  output logic       busy_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign accept = start_i && (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      StIdle: begin
        cmd_o.load      = accept && !stat_i.poll_mode;
        cmd_o.poll      = accept && stat_i.poll_mode && !stat_i.crc_request;
        cmd_o.crc_begin = accept && stat_i.poll_mode && stat_i.crc_request;
        if (cmd_o.crc_begin) begin
          state_d = StRun;
        end
      end
      StRun: begin
        cmd_o.run    = !stat_i.crc_done;
        cmd_o.finish = stat_i.crc_done;
        if (stat_i.crc_done) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

  // A walk always ends in the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (state_q == StIdle))
    else $error("checksum finish did not return to idle");

  // Items are only taken while idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !(cmd_o.load || cmd_o.poll || cmd_o.crc_begin))
    else $error("item taken while busy");

  // A started walk makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.crc_begin |=> busy_o)
    else $error("walk started without going busy");

endmodule

@@ design/mcrc_datapath.sv @@
// Datapath: payload store, service state, held results and the CRC-32 walk.
module mcrc_datapath import mcrc_pkg::*; #(
  parameter int unsigned PAYLOAD_MAX = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mcrc_cmd_t   cmd_i,
  output mcrc_stat_t  stat_o,
  input  logic [7:0]  ping_opcode_i,
  input  logic [7:0]  crc_opcode_i,
  input  logic        mode_i,
  input  logic [7:0]  byte_index_i,
  input  logic [7:0]  byte_value_i,
  input  logic [31:0] request_sequence_i,
  input  logic [7:0]  request_command_i,
  input  logic [15:0] request_length_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [31:0] answer_value_o,
  output logic [31:0] answer_crc_o,
  output logic [31:0] heartbeat_count_o,
  output logic [31:0] done_sequence_o,
  output logic        served_now_o
);

  localparam logic [16:0] PayloadMaxW = 17'(PAYLOAD_MAX);

  logic [31:0] beat_q, beat_d;
  logic [31:0] done_seq_q;
  logic [1:0]  held_status_q;
  logic [31:0] held_value_q;
  logic [31:0] held_crc_q;
  logic        strobe_q;
  logic        served_q;

  logic [StoreDepth-1:0] valid_q;
  logic                  vld_rd_q;
  logic                  oob_q;
  logic                  issue_q;
  logic [15:0]           pos_q;
  logic [15:0]           len_q;
  logic [31:0]           acc_q;

  logic        is_new, len_bad, is_ping, is_crc;
  logic        issue;
  logic [7:0]  rdata;
  logic [7:0]  fold_byte;

  assign is_new  = (request_sequence_i != done_seq_q);
  assign len_bad = ({1'b0, request_length_i} > PayloadMaxW);
  assign is_ping = (request_command_i == ping_opcode_i);
  assign is_crc  = (request_command_i == crc_opcode_i);
  assign beat_d  = beat_q + 32'd1;

  assign stat_o.poll_mode   = mode_i;
  assign stat_o.crc_request = is_new && !len_bad && !is_ping && is_crc;
  assign stat_o.crc_done    = (pos_q == len_q) && !issue_q;

  assign issue = cmd_i.run && (pos_q < len_q);

  mcrc_ram #(
    .WIDTH(8),
    .DEPTH(StoreDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.load),
    .waddr_i(byte_index_i),
    .wdata_i(byte_value_i),
    .re_i   (issue),
    .raddr_i(pos_q[StoreAddrW-1:0]),
    .rdata_o(rdata)
  );

  // Never-written entries and positions past the store read as zero.
  assign fold_byte = (vld_rd_q && !oob_q) ? rdata : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      beat_q        <= '0;
      done_seq_q    <= '0;
      held_status_q <= StatusOk;
      held_value_q  <= '0;
      held_crc_q    <= '0;
      strobe_q      <= 1'b0;
      served_q      <= 1'b0;
      issue_q       <= 1'b0;
      pos_q         <= '0;
    end else begin
      strobe_q <= cmd_i.poll || cmd_i.finish;
      issue_q  <= issue;
      if (cmd_i.load) begin
        valid_q[byte_index_i] <= 1'b1;
      end
      if (cmd_i.poll || cmd_i.crc_begin) begin
        beat_q   <= beat_d;
        served_q <= is_new;
      end
      if (cmd_i.poll && is_new) begin
        done_seq_q <= request_sequence_i;
        held_crc_q <= '0;
        if (len_bad) begin
          held_status_q <= StatusBadLength;
          held_value_q  <= '0;
        end else if (is_ping) begin
          held_status_q <= StatusOk;
          held_value_q  <= beat_d;
        end else begin
          held_status_q <= StatusUnsupported;
          held_value_q  <= '0;
        end
      end
      if (cmd_i.crc_begin) begin
        done_seq_q <= request_sequence_i;
        pos_q      <= '0;
      end else if (issue) begin
        pos_q <= pos_q + 16'd1;
      end
      if (cmd_i.finish) begin
        held_status_q <= StatusOk;
        held_value_q  <= acc_q ^ CrcOnes;
        held_crc_q    <= acc_q ^ CrcOnes;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.crc_begin) begin
      len_q <= request_length_i;
      acc_q <= CrcOnes;
    end else if (issue_q) begin
      acc_q <= crc_byte(acc_q, fold_byte);
    end
    if (issue) begin
      vld_rd_q <= valid_q[pos_q[StoreAddrW-1:0]];
      oob_q    <= |pos_q[15:StoreAddrW];
    end
  end

  assign result_valid_o    = strobe_q;
  assign status_o          = held_status_q;
  assign answer_value_o    = held_value_q;
  assign answer_crc_o      = held_crc_q;
  assign heartbeat_count_o = beat_q;
  assign done_sequence_o   = done_seq_q;
  assign served_now_o      = served_q;

  // The checksum is stored only after the last read byte has been folded in.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !issue_q)
    else $error("checksum finished with a byte still in flight");

  // The walk never reads beyond the requested length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.run |-> (pos_q <= len_q))
    else $error("payload walk ran past the request length");

  // Every tick answered at once and every finished walk raises the result strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.poll || cmd_i.finish) |=> strobe_q)
    else $error("result strobe missing");

endmodule

@@ design/mailbox_command_crc_service.sv @@
// Top level of the mailbox command service engine with CRC-32 over the payload.
//
// Usage. An item is transferred on a rising clock edge where start_i is high and
// busy_o is low. With mode_i low the item writes byte_value_i into the 256-byte
// payload store at byte_index_i; it gives no result. With mode_i high the item
// is one service tick: the heartbeat advances and, if the posted sequence
// differs from the last completed one, the request is run. Every tick gives
// exactly one result, shown for one cycle with result_valid_o high; the
// receiver cannot stall and must take it in that cycle. For a repeated
// sequence, a ping, a bad length or an unsupported command the result strobe
// follows in the next cycle, while a new item may already be transferred. A
// checksum request walks the payload one byte per cycle through the registered
// store read port, and the strobe comes in the first cycle in which busy_o is
// low again.
// Configuration writes on the cfg channel are always ready and should be made
// while the block is idle. Reset clears the heartbeat, the completed sequence,
// the held results and the valid bit of every payload entry, so the whole
// payload reads as zero at once; no clearing pass is needed.
module mailbox_command_crc_service import mcrc_pkg::*; #(
  parameter int unsigned PAYLOAD_MAX = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        mode_i,
  input  logic [7:0]  byte_index_i,
  input  logic [7:0]  byte_value_i,
  input  logic [31:0] request_sequence_i,
  input  logic [7:0]  request_command_i,
  input  logic [15:0] request_length_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [31:0] answer_value_o,
  output logic [31:0] answer_crc_o,
  output logic [31:0] heartbeat_count_o,
  output logic [31:0] done_sequence_o,
  output logic        served_now_o
);

  mcrc_cmd_t  cmd;
  mcrc_stat_t stat;

  logic [7:0] ping_opcode_q;
  logic [7:0] crc_opcode_q;

  // The register file takes a transfer in every cycle; writes to an index
  // outside the list are accepted and dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ping_opcode_q <= PingOpcodeReset;
      crc_opcode_q  <= CrcOpcodeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgPingOpcode: ping_opcode_q <= cfg_data_i;
        CfgCrcOpcode:  crc_opcode_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mcrc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  mcrc_datapath #(
    .PAYLOAD_MAX(PAYLOAD_MAX)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .ping_opcode_i     (ping_opcode_q),
    .crc_opcode_i      (crc_opcode_q),
    .mode_i            (mode_i),
    .byte_index_i      (byte_index_i),
    .byte_value_i      (byte_value_i),
    .request_sequence_i(request_sequence_i),
    .request_command_i (request_command_i),
    .request_length_i  (request_length_i),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .answer_value_o    (answer_value_o),
    .answer_crc_o      (answer_crc_o),
    .heartbeat_count_o (heartbeat_count_o),
    .done_sequence_o   (done_sequence_o),
    .served_now_o      (served_now_o)
  );

endmodule

@@ verif/mailbox_command_crc_service_tb.sv @@
// Self-checking testbench for the mailbox service engine: directed cases, then random traffic.
`timescale 1ns / 100ps

module mailbox_command_crc_service_tb import mcrc_pkg::*; ();

  // The block is built with its default payload limit, so lengths above 256 are invalid.
  localparam int unsigned PayloadMax = 256;
  localparam int unsigned RandomItems = 1800;
  localparam int unsigned PhaseCount = 6;
  // This bound on waiting for outstanding replies is comfortably above the time
  // for which a checksum over the full store keeps the block busy.
  localparam int unsigned DrainLimit = 2000;
  // Loads, pings and held replies finish in the cycle after their transfer.
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PrintLimit = 50;

  typedef struct packed {
    logic        mode;
    logic [7:0]  byte_index;
    logic [7:0]  byte_value;
    logic [31:0] req_seq;
    logic [7:0]  req_cmd;
    logic [15:0] req_len;
  } mailbox_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] answer_value;
    logic [31:0] answer_crc;
    logic [31:0] heartbeat;
    logic [31:0] done_seq;
    logic        served;
  } service_reply_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        mode = 1'b0;
  logic [7:0]  byte_index = '0;
  logic [7:0]  byte_value = '0;
  logic [31:0] req_seq = '0;
  logic [7:0]  req_cmd = '0;
  logic [15:0] req_len = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        reply_valid;
  logic [1:0]  status;
  logic [31:0] answer_value;
  logic [31:0] answer_crc;
  logic [31:0] heartbeat;
  logic [31:0] done_seq;
  logic        served_now;

  mailbox_command_crc_service #(
    .PAYLOAD_MAX(PayloadMax)
  ) dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .start_i           (start),
    .busy_o            (busy),
    .mode_i            (mode),
    .byte_index_i      (byte_index),
    .byte_value_i      (byte_value),
    .request_sequence_i(req_seq),
    .request_command_i (req_cmd),
    .request_length_i  (req_len),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .result_valid_o    (reply_valid),
    .status_o          (status),
    .answer_value_o    (answer_value),
    .answer_crc_o      (answer_crc),
    .heartbeat_count_o (heartbeat),
    .done_sequence_o   (done_seq),
    .served_now_o      (served_now)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Mirror of the block's state, advanced at every accepted transfer.
  logic [7:0]     payload_mirror [StoreDepth];
  logic [31:0]    beat_mirror;
  logic [31:0]    done_seq_mirror;
  logic [1:0]     held_status_mirror;
  logic [31:0]    held_value_mirror;
  logic [31:0]    held_crc_mirror;
  logic [7:0]     ping_opcode_mirror;
  logic [7:0]     crc_opcode_mirror;

  service_reply_t expected_replies [$];
  int unsigned    mismatch_count;
  int unsigned    items_issued;
  // While set, the sender offers items back to back with no idle cycles.
  bit             steady_feed;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PrintLimit) begin
      $display("%0t ns: reply error on %s: got %h, want %h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // Reflected CRC-32 over the first count bytes of the mirrored payload. Positions
  // beyond the store read as zero, although the default limit never reaches them.
  function automatic logic [31:0] payload_checksum(input logic [15:0] count);
    logic [31:0] acc;
    logic [7:0]  data;
    acc = CrcOnes;
    for (int pos = 0; pos < count; pos++) begin
      data = (pos < StoreDepth) ? payload_mirror[pos] : 8'h00;
      acc ^= {24'h0, data};
      repeat (BitsPerByte) acc = (acc >> 1) ^ (acc[0] ? CrcPoly : 32'h0);
    end
    return acc ^ CrcOnes;
  endfunction

  // Advances the mirror by one accepted item and queues the reply that a service
  // tick must produce. A load only updates the payload and produces nothing.
  function automatic void predict_reply(input mailbox_item_t it);
    service_reply_t reply;
    logic           served;
    served = 1'b0;
    if (!it.mode) begin
      payload_mirror[it.byte_index] = it.byte_value;
      return;
    end
    beat_mirror += 32'd1;
    // A sequence equal to the last completed one leaves the held answer in place.
    if (it.req_seq != done_seq_mirror) begin
      held_status_mirror = StatusOk;
      held_value_mirror = '0;
      held_crc_mirror = '0;
      if (it.req_len > PayloadMax) begin
        held_status_mirror = StatusBadLength;
      end else if (it.req_cmd == ping_opcode_mirror) begin
        // Ping wins when both opcodes are set to the same code.
        held_value_mirror = beat_mirror;
      end else if (it.req_cmd == crc_opcode_mirror) begin
        held_crc_mirror = payload_checksum(it.req_len);
        held_value_mirror = held_crc_mirror;
      end else begin
        held_status_mirror = StatusUnsupported;
      end
      done_seq_mirror = it.req_seq;
      served = 1'b1;
    end
    reply.status = held_status_mirror;
    reply.answer_value = held_value_mirror;
    reply.answer_crc = held_crc_mirror;
    reply.heartbeat = beat_mirror;
    reply.done_seq = done_seq_mirror;
    reply.served = served;
    expected_replies.push_back(reply);
  endfunction

  // Offers one item after a random number of idle cycles (none while steady_feed is
  // set) and returns on the edge at which it is transferred. start is left high, so
  // that a following item with no idle gap can go out on the very next cycle.
  task automatic send_item(input mailbox_item_t it);
    int unsigned gap;
    gap = steady_feed ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= it.mode;
    byte_index <= it.byte_index;
    byte_value <= it.byte_value;
    req_seq <= it.req_seq;
    req_cmd <= it.req_cmd;
    req_len <= it.req_len;
    do @(posedge clk); while (busy !== 1'b0);
    predict_reply(it);
    items_issued++;
  endtask

  // Load item; the request fields carry junk, which the block must ignore.
  task automatic load_byte(input logic [7:0] idx, input logic [7:0] value);
    mailbox_item_t it;
    it.mode = 1'b0;
    it.byte_index = idx;
    it.byte_value = value;
    it.req_seq = $urandom;
    it.req_cmd = 8'($urandom);
    it.req_len = 16'($urandom);
    send_item(it);
  endtask

  // Service tick; the payload fields carry junk, which the block must ignore.
  task automatic poll_request(input logic [31:0] seq, input logic [7:0] cmd,
                              input logic [15:0] len);
    mailbox_item_t it;
    it.mode = 1'b1;
    it.byte_index = 8'($urandom);
    it.byte_value = 8'($urandom);
    it.req_seq = seq;
    it.req_cmd = cmd;
    it.req_len = len;
    send_item(it);
  endtask

  // Stops offering items and waits for every outstanding reply, then a few cycles
  // more so that a load still in flight has completed. Anything still awaited
  // after the bound counts as a lost reply.
  task automatic drain_replies();
    int unsigned waited;
    start <= 1'b0;
    waited = 0;
    while (expected_replies.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk);
    while (expected_replies.size() != 0) begin
      report_mismatch("missing reply, sequence", 32'h0, expected_replies[0].done_seq);
      void'(expected_replies.pop_front());
    end
  endtask

  // Writes both opcode registers in two consecutive transfers on the config channel.
  // Only called with the block idle.
  task automatic write_opcodes(input logic [7:0] ping_code, input logic [7:0] crc_code);
    logic [7:0] reg_index [2];
    logic [7:0] reg_value [2];
    reg_index[0] = CfgPingOpcode;
    reg_index[1] = CfgCrcOpcode;
    reg_value[0] = ping_code;
    reg_value[1] = crc_code;
    for (int r = 0; r < 2; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_index[r];
      cfg_data <= reg_value[r];
      do @(posedge clk); while (cfg_ready !== 1'b1);
    end
    cfg_valid <= 1'b0;
    ping_opcode_mirror = ping_code;
    crc_opcode_mirror = crc_code;
  endtask

  // Each reply is on the outputs for one cycle and is taken at the edge that ends
  // that cycle; it is matched against the oldest expectation field by field.
  always @(posedge clk) begin : reply_check
    service_reply_t got;
    service_reply_t want;
    if (rst_n && reply_valid) begin
      got.status = status;
      got.answer_value = answer_value;
      got.answer_crc = answer_crc;
      got.heartbeat = heartbeat;
      got.done_seq = done_seq;
      got.served = served_now;
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected reply, sequence", got.done_seq, 32'h0);
      end else begin
        want = expected_replies.pop_front();
        if (got.status !== want.status) begin
          report_mismatch("status", 32'(got.status), 32'(want.status));
        end
        if (got.answer_value !== want.answer_value) begin
          report_mismatch("answer value", got.answer_value, want.answer_value);
        end
        if (got.answer_crc !== want.answer_crc) begin
          report_mismatch("answer crc", got.answer_crc, want.answer_crc);
        end
        if (got.heartbeat !== want.heartbeat) begin
          report_mismatch("heartbeat", got.heartbeat, want.heartbeat);
        end
        if (got.done_seq !== want.done_seq) begin
          report_mismatch("done sequence", got.done_seq, want.done_seq);
        end
        if (got.served !== want.served) begin
          report_mismatch("served flag", 32'(got.served), 32'(want.served));
        end
      end
    end
  end

  // Reset values: sequence zero counts as done, and the opcodes are ping 0, crc 1.
  task automatic test_reset_defaults();
    poll_request(32'h0, PingOpcodeReset, 16'd0);
    poll_request(32'd5, PingOpcodeReset, 16'd0);
    poll_request(32'd5, CrcOpcodeReset, 16'd8);
    poll_request(32'd6, CrcOpcodeReset, 16'd0);
    poll_request(32'd7, CrcOpcodeReset, 16'd4);
  endtask

  // Store ends, full and over-long lengths, unsupported codes, held replies and
  // ignored fields carrying all ones.
  task automatic test_payload_extremes();
    mailbox_item_t it;
    load_byte(8'd0, 8'hFF);
    load_byte(8'd255, 8'hFF);
    load_byte(8'd128, 8'h5A);
    poll_request(32'hFFFF_FFFF, CrcOpcodeReset, 16'd256);
    poll_request(32'h0, CrcOpcodeReset, 16'd257);
    poll_request(32'd1, PingOpcodeReset, 16'hFFFF);
    poll_request(32'd2, 8'hFF, 16'd3);
    poll_request(32'd2, CrcOpcodeReset, 16'd1);
    it.mode = 1'b0;
    it.byte_index = 8'd1;
    it.byte_value = 8'h00;
    it.req_seq = 32'hFFFF_FFFF;
    it.req_cmd = 8'hFF;
    it.req_len = 16'hFFFF;
    send_item(it);
    it.mode = 1'b1;
    it.byte_index = 8'hFF;
    it.byte_value = 8'hFF;
    it.req_seq = 32'd3;
    it.req_cmd = CrcOpcodeReset;
    it.req_len = 16'd1;
    send_item(it);
  endtask

  // Opcode registers at their extremes, including both set to one code.
  task automatic test_opcode_selection();
    drain_replies();
    write_opcodes(8'hFF, 8'hFF);
    poll_request(32'd10, 8'hFF, 16'd4);
    drain_replies();
    write_opcodes(8'h00, 8'hFF);
    poll_request(32'd11, 8'hFF, 16'd256);
    poll_request(32'd12, 8'h00, 16'd0);
    poll_request(32'd13, 8'h01, 16'd1);
  endtask

  // Random traffic in phases, each under its own opcode setting. Most of it is
  // well-formed exchanges: a few payload loads inside the requested length, one
  // tick with a fresh sequence, then ticks that repeat the completed sequence.
  // The rest is noise and malformed ticks.
  task automatic test_random_traffic();
    int unsigned    target;
    int unsigned    pick;
    int unsigned    n_loads;
    logic [15:0]    len;
    logic [7:0]     cmd;
    logic [7:0]     ping_code;
    logic [7:0]     crc_code;
    mailbox_item_t  it;
    for (int phase = 0; phase < PhaseCount; phase++) begin
      drain_replies();
      case (phase)
        0: begin
          ping_code = 8'h00;
          crc_code = 8'hFF;
        end
        1: begin
          ping_code = 8'hFF;
          crc_code = 8'h00;
        end
        2: begin
          ping_code = 8'($urandom);
          crc_code = ping_code;
        end
        default: begin
          ping_code = 8'($urandom);
          crc_code = 8'($urandom);
        end
      endcase
      write_opcodes(ping_code, crc_code);
      target = items_issued + RandomItems / PhaseCount;
      while (items_issued < target) begin
        if ($urandom_range(0, 39) == 0) steady_feed = ~steady_feed;
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
          case ($urandom_range(0, 15))
            0: len = 16'($urandom_range(0, PayloadMax));
            1: len = 16'($urandom_range(PayloadMax + 1, 16'hFFFF));
            default: len = 16'($urandom_range(0, 24));
          endcase
          n_loads = $urandom_range(0, 8);
          repeat (n_loads) begin
            if (len != 0 && len <= PayloadMax) begin
              load_byte(8'($urandom_range(0, len - 1)), 8'($urandom));
            end else begin
              load_byte(8'($urandom), 8'($urandom));
            end
          end
          case ($urandom_range(0, 7))
            0, 1, 2: cmd = ping_opcode_mirror;
            3, 4, 5, 6: cmd = crc_opcode_mirror;
            default: cmd = 8'($urandom);
          endcase
          poll_request($urandom, cmd, len);
          repeat ($urandom_range(0, 2)) begin
            poll_request(done_seq_mirror, 8'($urandom), 16'($urandom));
          end
        end else if (pick <= 7) begin
          it.mode = 1'($urandom);
          it.byte_index = 8'($urandom);
          it.byte_value = 8'($urandom);
          it.req_seq = $urandom_range(0, 1) ? done_seq_mirror : 32'($urandom);
          it.req_cmd = 8'($urandom);
          it.req_len = 16'($urandom);
          send_item(it);
        end else if (pick == 8) begin
          poll_request(done_seq_mirror, 8'($urandom), 16'($urandom));
        end else begin
          // Sequence zero, or a fresh sequence with an over-long length.
          if ($urandom_range(0, 1)) begin
            poll_request(32'h0, 8'($urandom), 16'($urandom));
          end else begin
            poll_request($urandom, 8'($urandom),
                         16'($urandom_range(PayloadMax + 1, 16'hFFFF)));
          end
        end
      end
    end
    steady_feed = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < StoreDepth; i++) payload_mirror[i] = 8'h00;
    beat_mirror = '0;
    done_seq_mirror = '0;
    held_status_mirror = StatusOk;
    held_value_mirror = '0;
    held_crc_mirror = '0;
    ping_opcode_mirror = PingOpcodeReset;
    crc_opcode_mirror = CrcOpcodeReset;
    mismatch_count = 0;
    items_issued = 0;
    steady_feed = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_payload_extremes();
    test_opcode_selection();
    test_random_traffic();
    drain_replies();
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog: several times the slowest legal run, every item a full-store
  // checksum after the longest idle gap.
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ filelist.f @@
design/mcrc_pkg.sv
design/mcrc_ram.sv
design/mcrc_ctrl.sv
design/mcrc_datapath.sv
design/mailbox_command_crc_service.sv
verif/mailbox_command_crc_service_tb.sv
